// File: design/tgc_pkg.sv
`timescale 1ns / 1ps

package tgc_pkg;

	localparam int CITY_W = 8;
	localparam int RANK_W = 7;
	localparam int SRC_W = 2;
	localparam int DIST_IN_W = 24;
	localparam logic [CITY_W-1:0] CITY_COUNT_RESET = 8'd128;

	localparam logic OP_LOAD = 1'b0;
	localparam logic OP_CROSS = 1'b1;

	localparam logic [SRC_W-1:0] SRC_A = 2'd0;
	localparam logic [SRC_W-1:0] SRC_B = 2'd1;
	localparam logic [SRC_W-1:0] SRC_RAND = 2'd2;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_EVAL,
		ST_READ_A,
		ST_READ_B,
		ST_RANK,
		ST_COMMIT
	} state_t;

	// Search token that walks the cell row, one cell per cycle.
	typedef struct packed {
		logic              valid;
		logic              found;
		logic [RANK_W-1:0] rank;
		logic [CITY_W-1:0] city;
	} token_t;

	// Broadcast control from the sequencer to every cell.
	typedef struct packed {
		logic [CITY_W-1:0] n;
		logic              clr;
		logic              set_en;
		logic [CITY_W-1:0] set_city;
		logic [CITY_W-1:0] qa;
		logic [CITY_W-1:0] qb;
	} cell_ctl_t;

endpackage

// File: design/tsp_greedy_crossover_unit.sv
`timescale 1ns / 1ps

// Channel   Direction  Ports                       Contents
// s_        in         s_tvalid/s_tready          tdata: from_city, to_city, distance,
//                      s_tdata[63:0] s_tuser[0]    first_position, parent_a_city,
//                                                  parent_b_city, random_rank; tuser: opcode
// m_        out        m_tvalid/m_tready          tdata: child_city; tuser: choice_source;
//                      m_tdata[7:0] m_tuser[1:0]   tlast: is_last
// cfg_      in         cfg_we, cfg_wdata[7:0]     city_count
//
// A load item is written into the distance RAM in the cycle it is accepted, if both cities lie in 1..MAX_CITIES.
// A crossover item goes from evaluation straight to commit when a parent city wins outright,
// through two reads in turn on the single RAM read port when the two distances decide,
// and through the rank search, whose token walks the whole row of cells, when no parent is free.
// Reset clears the used map, the previous city, the position count and city_count to 128.
// A full output register holds the item in its final cycle until m_tready frees it.
module tsp_greedy_crossover_unit #(
	parameter int MAX_CITIES = 128,
	parameter int DIST_BITS = 24
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [63:0] s_tdata,   // from_city, to_city, distance, first_position,
	                               // parent_a_city, parent_b_city, random_rank
	input  logic [0:0]  s_tuser,   // opcode
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [7:0]  m_tdata,   // child_city
	output logic [1:0]  m_tuser,   // choice_source
	output logic        m_tlast,
	input  logic        cfg_we,
	input  logic [7:0]  cfg_wdata
);

	localparam int DEPTH = MAX_CITIES * MAX_CITIES;
	localparam int AW = $clog2(DEPTH);
	localparam int CAP = (MAX_CITIES > 255) ? 255 : MAX_CITIES;

	logic [tgc_pkg::CITY_W-1:0]    in_from;
	logic [tgc_pkg::CITY_W-1:0]    in_to;
	logic [tgc_pkg::DIST_IN_W-1:0] in_dist;
	logic                          in_first;
	logic [tgc_pkg::CITY_W-1:0]    in_a;
	logic [tgc_pkg::CITY_W-1:0]    in_b;
	logic [tgc_pkg::RANK_W-1:0]    in_rank;

	tgc_pkg::state_t state_q, state_next;

	logic [tgc_pkg::CITY_W-1:0] cc_q;
	logic [tgc_pkg::CITY_W-1:0] n_eff;
	logic [tgc_pkg::CITY_W-1:0] a_q, b_q, prev_q, pos_q;
	logic [tgc_pkg::RANK_W-1:0] rank_q;
	logic                       first_q;
	logic [DIST_BITS-1:0]       dist_a_q;
	logic [tgc_pkg::CITY_W-1:0] pick_city_q;
	logic [tgc_pkg::SRC_W-1:0]  pick_src_q;

	logic                       out_valid_q;
	logic [tgc_pkg::CITY_W-1:0] out_city_q;
	logic [tgc_pkg::SRC_W-1:0]  out_src_q;
	logic                       out_last_q;

	logic                       accept;
	logic                       out_free;
	logic                       fa, fb;
	logic                       pick_we;
	logic [tgc_pkg::CITY_W-1:0] pick_city;
	logic [tgc_pkg::SRC_W-1:0]  pick_src;
	logic                       dist_a_we;
	logic                       launch;
	logic                       commit_fire;

	logic                       ram_we, ram_re;
	logic [AW-1:0]              ram_waddr, ram_raddr;
	logic [DIST_BITS-1:0]       ram_rdata;
	logic [tgc_pkg::CITY_W-1:0] rd_col;
	logic                       load_in_range;

	tgc_pkg::cell_ctl_t ctl;
	tgc_pkg::token_t    tok [MAX_CITIES+1];
	logic [MAX_CITIES-1:0] hit_a_v, hit_b_v;

	assign in_from = s_tdata[7:0];
	assign in_to = s_tdata[15:8];
	assign in_dist = s_tdata[39:16];
	assign in_first = s_tdata[40];
	assign in_a = s_tdata[48:41];
	assign in_b = s_tdata[56:49];
	assign in_rank = s_tdata[63:57];

	assign accept = s_tvalid && s_tready;
	assign out_free = !out_valid_q || m_tready;

	always_comb begin
		if (cc_q == '0) begin
			n_eff = tgc_pkg::CITY_W'(1);
		end else if (int'(cc_q) > CAP) begin
			n_eff = tgc_pkg::CITY_W'(CAP);
		end else begin
			n_eff = cc_q;
		end
	end

	assign fa = (a_q != '0) && (a_q <= n_eff) && !(|hit_a_v);
	assign fb = (b_q != '0) && (b_q <= n_eff) && !(|hit_b_v);

	// Distance RAM
	assign load_in_range = (in_from != '0) && (int'(in_from) <= MAX_CITIES)
		&& (in_to != '0) && (int'(in_to) <= MAX_CITIES);
	assign ram_we = accept && (s_tuser[0] == tgc_pkg::OP_LOAD) && load_in_range;
	assign ram_waddr = AW'((int'(in_from) - 1) * MAX_CITIES + int'(in_to) - 1);
	assign ram_raddr = AW'((int'(prev_q) - 1) * MAX_CITIES + int'(rd_col) - 1);

	tgc_ram #(
		.WIDTH(DIST_BITS),
		.DEPTH(DEPTH)
	) u_dist_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (DIST_BITS'(in_dist)),
		.re    (ram_re),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	// Row of cells holding the used map
	assign ctl.n = n_eff;
	assign ctl.clr = accept && (s_tuser[0] == tgc_pkg::OP_CROSS) && in_first;
	assign ctl.set_en = commit_fire;
	assign ctl.set_city = pick_city_q;
	assign ctl.qa = a_q;
	assign ctl.qb = b_q;

	assign tok[0].valid = launch;
	assign tok[0].found = 1'b0;
	assign tok[0].rank = rank_q;
	assign tok[0].city = '0;

	for (genvar i = 0; i < MAX_CITIES; i++) begin : g_cell
		tgc_cell #(
			.CELL_CITY(i + 1)
		) u_cell (
			.clk     (clk),
			.arst_n  (arst_n),
			.ctl     (ctl),
			.tok_in  (tok[i]),
			.tok_out (tok[i+1]),
			.hit_a   (hit_a_v[i]),
			.hit_b   (hit_b_v[i])
		);
	end

	// Sequencer
	always_comb begin
		state_next = state_q;
		unique case (state_q)
			tgc_pkg::ST_IDLE: begin
				if (s_tvalid && (s_tuser[0] == tgc_pkg::OP_CROSS)) begin
					state_next = tgc_pkg::ST_EVAL;
				end
			end
			tgc_pkg::ST_EVAL: begin
				priority if (first_q) begin
					state_next = (fa || fb) ? tgc_pkg::ST_COMMIT : tgc_pkg::ST_RANK;
				end else if (fa && fb) begin
					state_next = (prev_q == '0) ? tgc_pkg::ST_COMMIT : tgc_pkg::ST_READ_A;
				end else if (fa || fb) begin
					state_next = tgc_pkg::ST_COMMIT;
				end else begin
					state_next = tgc_pkg::ST_RANK;
				end
			end
			tgc_pkg::ST_READ_A: state_next = tgc_pkg::ST_READ_B;
			tgc_pkg::ST_READ_B: state_next = tgc_pkg::ST_COMMIT;
			tgc_pkg::ST_RANK: begin
				if (tok[MAX_CITIES].valid) begin
					state_next = tgc_pkg::ST_COMMIT;
				end
			end
			tgc_pkg::ST_COMMIT: begin
				if (out_free) begin
					state_next = tgc_pkg::ST_IDLE;
				end
			end
			default: state_next = tgc_pkg::ST_IDLE;
		endcase
	end

	always_comb begin
		s_tready = 1'b0;
		pick_we = 1'b0;
		pick_city = a_q;
		pick_src = tgc_pkg::SRC_A;
		dist_a_we = 1'b0;
		ram_re = 1'b0;
		rd_col = a_q;
		launch = 1'b0;
		commit_fire = 1'b0;
		unique case (state_q)
			tgc_pkg::ST_IDLE: s_tready = 1'b1;
			tgc_pkg::ST_EVAL: begin
				priority if (first_q) begin
					if (fa) begin
						pick_we = 1'b1;
					end else if (fb) begin
						pick_we = 1'b1;
						pick_city = b_q;
						pick_src = tgc_pkg::SRC_B;
					end else begin
						launch = 1'b1;
					end
				end else if (fa && fb) begin
					if (prev_q == '0) begin
						pick_we = 1'b1;
					end else begin
						ram_re = 1'b1;
					end
				end else if (fa) begin
					pick_we = 1'b1;
				end else if (fb) begin
					pick_we = 1'b1;
					pick_city = b_q;
					pick_src = tgc_pkg::SRC_B;
				end else begin
					launch = 1'b1;
				end
			end
			tgc_pkg::ST_READ_A: begin
				dist_a_we = 1'b1;
				ram_re = 1'b1;
				rd_col = b_q;
			end
			tgc_pkg::ST_READ_B: begin
				pick_we = 1'b1;
				if (dist_a_q > ram_rdata) begin
					pick_city = b_q;
					pick_src = tgc_pkg::SRC_B;
				end
			end
			tgc_pkg::ST_RANK: begin
				if (tok[MAX_CITIES].valid) begin
					pick_we = 1'b1;
					pick_city = tok[MAX_CITIES].city;
					pick_src = tgc_pkg::SRC_RAND;
				end
			end
			tgc_pkg::ST_COMMIT: commit_fire = out_free;
			default: s_tready = 1'b0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= tgc_pkg::ST_IDLE;
			cc_q <= tgc_pkg::CITY_COUNT_RESET;
			prev_q <= '0;
			pos_q <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_next;
			if (cfg_we) begin
				cc_q <= cfg_wdata;
			end
			if (ctl.clr) begin
				pos_q <= '0;
			end else if (commit_fire) begin
				pos_q <= pos_q + tgc_pkg::CITY_W'(1);
			end
			if (commit_fire) begin
				prev_q <= pick_city_q;
				out_valid_q <= 1'b1;
			end else if (m_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			a_q <= in_a;
			b_q <= in_b;
			rank_q <= in_rank;
			first_q <= in_first;
		end
		if (dist_a_we) begin
			dist_a_q <= ram_rdata;
		end
		if (pick_we) begin
			pick_city_q <= pick_city;
			pick_src_q <= pick_src;
		end
		if (commit_fire) begin
			out_city_q <= pick_city_q;
			out_src_q <= pick_src_q;
			out_last_q <= (pos_q == (n_eff - tgc_pkg::CITY_W'(1)));
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata = out_city_q;
	assign m_tuser = out_src_q;
	assign m_tlast = out_last_q;

endmodule

// File: design/tgc_ram.sv
`timescale 1ns / 1ps

module tgc_ram #(
	parameter int WIDTH = 24,
	parameter int DEPTH = 16384
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

// File: design/tgc_cell.sv
`timescale 1ns / 1ps

module tgc_cell #(
	parameter int CELL_CITY = 1
) (
	input  logic               clk,
	input  logic               arst_n,
	input  tgc_pkg::cell_ctl_t ctl,
	input  tgc_pkg::token_t    tok_in,
	output tgc_pkg::token_t    tok_out,
	output logic               hit_a,
	output logic               hit_b
);

	logic            used_q;
	logic            in_range;
	logic            free;
	tgc_pkg::token_t tok_next;
	tgc_pkg::token_t tok_q;

	assign in_range = int'(ctl.n) >= CELL_CITY;
	assign free = in_range && !used_q;
	assign hit_a = used_q && (int'(ctl.qa) == CELL_CITY);
	assign hit_b = used_q && (int'(ctl.qb) == CELL_CITY);

	// A free city becomes the candidate; the token stops changing once the rank is reached.
	always_comb begin
		tok_next = tok_in;
		if (tok_in.valid && !tok_in.found && free) begin
			tok_next.city = tgc_pkg::CITY_W'(CELL_CITY);
			if (tok_in.rank == '0) begin
				tok_next.found = 1'b1;
			end else begin
				tok_next.rank = tok_in.rank - tgc_pkg::RANK_W'(1);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			used_q <= 1'b0;
			tok_q <= '0;
		end else begin
			tok_q <= tok_next;
			priority if (ctl.clr) begin
				used_q <= 1'b0;
			end else if (ctl.set_en && (int'(ctl.set_city) == CELL_CITY)) begin
				used_q <= 1'b1;
			end else begin
				used_q <= used_q;
			end
		end
	end

	assign tok_out = tok_q;

endmodule

// File: tb/tsp_greedy_crossover_unit_tb.sv
`timescale 1ns / 1ps

module tsp_greedy_crossover_unit_tb;

	localparam int MAX_C = 128;
	localparam int TABLE_SIZE = MAX_C * MAX_C;

	typedef struct packed {
		logic [tgc_pkg::RANK_W-1:0]    rank;
		logic [tgc_pkg::CITY_W-1:0]    parent_b;
		logic [tgc_pkg::CITY_W-1:0]    parent_a;
		logic                          first_pos;
		logic [tgc_pkg::DIST_IN_W-1:0] distance;
		logic [tgc_pkg::CITY_W-1:0]    to_city;
		logic [tgc_pkg::CITY_W-1:0]    from_city;
	} item_word_t;

	typedef struct packed {
		logic [tgc_pkg::CITY_W-1:0] city;
		logic [tgc_pkg::SRC_W-1:0]  src;
		logic                       last_pos;
	} child_t;

	class tour_scoreboard;
		logic [tgc_pkg::DIST_IN_W-1:0] dist_ram [TABLE_SIZE];
		bit dist_known [TABLE_SIZE];
		bit used [MAX_C];
		int prev_city;
		logic [7:0] pos;
		logic [7:0] city_count;
		child_t pending_children [$];
		int errors;

		function new();
			prev_city = 0;
			pos = '0;
			city_count = tgc_pkg::CITY_COUNT_RESET;
			errors = 0;
		endfunction

		function int tour_len();
			if (city_count == 0) return 1;
			if (city_count > MAX_C) return MAX_C;
			return int'(city_count);
		endfunction

		function bit is_free(int c);
			if (c < 1 || c > tour_len()) return 0;
			return !used[c-1];
		endfunction

		function int entry(int to);
			return (prev_city - 1) * MAX_C + to - 1;
		endfunction

		// A pick between two free parent cities reads two distances from the previous city.
		function bit reads_distance(int a, int b, bit first_pos);
			return !first_pos && is_free(a) && is_free(b)
				&& prev_city >= 1 && prev_city <= MAX_C;
		endfunction

		function logic [tgc_pkg::DIST_IN_W-1:0] dist_from_prev(int to);
			if (prev_city < 1 || prev_city > MAX_C || to < 1 || to > MAX_C) return '0;
			return dist_known[entry(to)] ? dist_ram[entry(to)] : '0;
		endfunction

		function int rank_pick(int rank);
			int seen;
			int last_free;
			seen = 0;
			last_free = 0;
			for (int c = 1; c <= tour_len(); c++) begin
				if (!used[c-1]) begin
					if (seen == rank) return c;
					seen++;
					last_free = c;
				end
			end
			return last_free;
		endfunction

		function void note_item(logic op, logic [63:0] data);
			item_word_t w;
			int a;
			int b;
			int f;
			int t;
			int city;
			logic [tgc_pkg::SRC_W-1:0] src;
			child_t r;
			w = data;
			if (op == tgc_pkg::OP_LOAD) begin
				f = int'(w.from_city);
				t = int'(w.to_city);
				if (f >= 1 && f <= MAX_C && t >= 1 && t <= MAX_C) begin
					dist_ram[(f - 1) * MAX_C + t - 1] = w.distance;
					dist_known[(f - 1) * MAX_C + t - 1] = 1;
				end
				return;
			end
			a = int'(w.parent_a);
			b = int'(w.parent_b);
			if (w.first_pos) begin
				foreach (used[i]) used[i] = 0;
				pos = '0;
			end
			if (w.first_pos) begin
				if (is_free(a)) begin
					city = a;
					src = tgc_pkg::SRC_A;
				end else if (is_free(b)) begin
					city = b;
					src = tgc_pkg::SRC_B;
				end else begin
					city = rank_pick(int'(w.rank));
					src = tgc_pkg::SRC_RAND;
				end
			end else if (is_free(a) && is_free(b)) begin
				if (dist_from_prev(a) <= dist_from_prev(b)) begin
					city = a;
					src = tgc_pkg::SRC_A;
				end else begin
					city = b;
					src = tgc_pkg::SRC_B;
				end
			end else if (is_free(a)) begin
				city = a;
				src = tgc_pkg::SRC_A;
			end else if (is_free(b)) begin
				city = b;
				src = tgc_pkg::SRC_B;
			end else begin
				city = rank_pick(int'(w.rank));
				src = tgc_pkg::SRC_RAND;
			end
			if (city >= 1 && city <= MAX_C) used[city-1] = 1;
			prev_city = city;
			r.city = tgc_pkg::CITY_W'(city);
			r.src = src;
			r.last_pos = (int'(pos) == tour_len() - 1);
			pending_children.push_back(r);
			pos = pos + 8'd1;
		endfunction

		function void check_child(logic [7:0] city, logic [1:0] src, logic last_flag);
			child_t e;
			if (pending_children.size() == 0) begin
				$error("child_city: no item waiting, actual %0d", city);
				errors++;
				return;
			end
			e = pending_children.pop_front();
			if (city !== e.city) begin
				$error("child_city: expected %0d, actual %0d", e.city, city);
				errors++;
			end
			if (src !== e.src) begin
				$error("choice_source: expected %0d, actual %0d", e.src, src);
				errors++;
			end
			if (last_flag !== e.last_pos) begin
				$error("is_last: expected %0d, actual %0d", e.last_pos, last_flag);
				errors++;
			end
		endfunction
	endclass

	logic        clk;
	logic        arst_n;
	logic        s_tvalid;
	logic        s_tready;
	logic [63:0] s_tdata;
	logic [0:0]  s_tuser;
	logic        m_tvalid;
	logic        m_tready;
	logic [7:0]  m_tdata;
	logic [1:0]  m_tuser;
	logic        m_tlast;
	logic        cfg_we;
	logic [7:0]  cfg_wdata;

	tour_scoreboard sb;
	bit quiet;
	int items_sent;

	tsp_greedy_crossover_unit DUT (
		.clk(clk),
		.arst_n(arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata(s_tdata),
		.s_tuser(s_tuser),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata(m_tdata),
		.m_tuser(m_tuser),
		.m_tlast(m_tlast),
		.cfg_we(cfg_we),
		.cfg_wdata(cfg_wdata)
	);

	initial clk = 1'b0;
	always #5 clk = ~clk;

	function automatic logic [tgc_pkg::DIST_IN_W-1:0] rand_dist();
		case ($urandom_range(0, 5))
			0: return '0;
			1: return '1;
			2, 3: return tgc_pkg::DIST_IN_W'($urandom_range(0, 3));
			default: return tgc_pkg::DIST_IN_W'($urandom);
		endcase
	endfunction

	function automatic int stray_city(int n);
		if ($urandom_range(0, 1) == 0) return 0;
		return $urandom_range(n + 1, 255);
	endfunction

	function automatic int any_city(int n);
		if ($urandom_range(0, 3) != 0) return $urandom_range(1, n);
		return $urandom_range(0, 255);
	endfunction

	task automatic send_item(input logic op, input logic [63:0] data);
		int gap;
		gap = quiet ? 0 : $urandom_range(0, 17);
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser <= op;
		s_tdata <= data;
		do @(posedge clk); while (!s_tready);
		sb.note_item(op, data);
		items_sent++;
	endtask

	task automatic send_load(input int from_c, input int to_c,
		input logic [tgc_pkg::DIST_IN_W-1:0] d);
		item_word_t w;
		w = {$urandom, $urandom};
		w.from_city = tgc_pkg::CITY_W'(from_c);
		w.to_city = tgc_pkg::CITY_W'(to_c);
		w.distance = d;
		send_item(tgc_pkg::OP_LOAD, w);
	endtask

	task automatic send_cross(input bit first_pos, input int a, input int b, input int rank);
		item_word_t w;
		if (sb.reads_distance(a, b, first_pos)) begin
			if (!sb.dist_known[sb.entry(a)]) send_load(sb.prev_city, a, rand_dist());
			if (!sb.dist_known[sb.entry(b)]) send_load(sb.prev_city, b, rand_dist());
		end
		w = {$urandom, $urandom};
		w.first_pos = first_pos;
		w.parent_a = tgc_pkg::CITY_W'(a);
		w.parent_b = tgc_pkg::CITY_W'(b);
		w.rank = tgc_pkg::RANK_W'(rank);
		send_item(tgc_pkg::OP_CROSS, w);
	endtask

	// Stops the sender until every child city has come back, then keeps waiting for the time given by extra.
	task automatic settle(input int extra);
		s_tvalid <= 1'b0;
		do @(posedge clk); while (sb.pending_children.size() != 0);
		repeat (extra) @(posedge clk);
	endtask

	task automatic write_city_count(input logic [7:0] value);
		settle(MAX_C + 8);
		cfg_we <= 1'b1;
		cfg_wdata <= value;
		@(posedge clk);
		cfg_we <= 1'b0;
		sb.city_count = value;
	endtask

	task automatic run_tour(input int len);
		int n;
		int j;
		int tmp;
		int a;
		int b;
		int pa [MAX_C];
		int pb [MAX_C];
		n = sb.tour_len();
		for (int c = 0; c < n; c++) begin
			pa[c] = c + 1;
			pb[c] = c + 1;
		end
		for (int i = n - 1; i > 0; i--) begin
			j = $urandom_range(0, i);
			tmp = pa[i];
			pa[i] = pa[j];
			pa[j] = tmp;
			j = $urandom_range(0, i);
			tmp = pb[i];
			pb[i] = pb[j];
			pb[j] = tmp;
		end
		for (int i = 0; i < len; i++) begin
			a = pa[i % n];
			b = pb[i % n];
			if ($urandom_range(0, 24) == 0) a = stray_city(n);
			if ($urandom_range(0, 24) == 0) b = stray_city(n);
			send_cross(i == 0, a, b, $urandom_range(0, 127));
		end
	endtask

	task automatic noise_item();
		int n;
		n = sb.tour_len();
		if ($urandom_range(0, 1) == 0)
			send_cross($urandom_range(0, 9) == 0, any_city(n), any_city(n),
				$urandom_range(0, 127));
		else
			send_load(any_city(n), any_city(n), rand_dist());
	endtask

	task automatic run_phase(input logic [7:0] count, input int budget, input bit full_tour);
		int start;
		int n;
		int r;
		int len;
		write_city_count(count);
		quiet = ($urandom_range(0, 3) == 0);
		n = sb.tour_len();
		start = items_sent;
		if (full_tour) run_tour(n);
		while (items_sent - start < budget) begin
			r = $urandom_range(0, 99);
			if (r < 3) begin
				settle(0);
			end else if (r < 75) begin
				if (n > 32) len = $urandom_range(1, 24);
				else if (r < 10) len = n + $urandom_range(1, 3);
				else if (r < 16) len = $urandom_range(1, n);
				else len = n;
				run_tour(len);
			end else begin
				noise_item();
			end
		end
	endtask

	initial begin
		sb = new();
		arst_n = 1'b0;
		s_tvalid = 1'b0;
		s_tdata = '0;
		s_tuser = '0;
		cfg_we = 1'b0;
		cfg_wdata = '0;
		quiet = 1'b0;
		items_sent = 0;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Straight after reset there is no previous city, so no distance is read and parent A is taken.
		send_cross(0, 2, 1, 0);
		write_city_count(8'd4);
		send_load(0, 1, '1);
		send_load(1, 0, '1);
		send_load(129, 255, '0);
		send_load(200, 3, 24'h5a5a5a);
		send_load(3, 1, '1);
		send_load(3, 2, '0);
		send_cross(1, 0, 3, 0);
		send_cross(0, 1, 2, 0);
		send_cross(0, 1, 2, 0);
		send_cross(0, 1, 200, 127);
		send_cross(0, 2, 3, 0);
		send_cross(1, 5, 0, 1);
		send_load(2, 3, 24'd7);
		send_load(2, 4, 24'd7);
		send_cross(0, 3, 4, 0);
		send_load(3, 4, 24'd16);
		send_load(3, 1, 24'd15);
		send_cross(0, 4, 1, 127);
		send_cross(1, 255, 200, 0);
		send_cross(1, 3, 1, 0);
		send_cross(0, 3, 2, 0);

		// A count of zero acts as one; a long run without a restart wraps the position counter.
		write_city_count(8'd0);
		send_cross(1, 1, 0, 0);
		repeat (259) send_cross(0, $urandom_range(0, 255), $urandom_range(0, 255),
			$urandom_range(0, 127));

		run_phase(8'd6, 90, 0);
		run_phase(8'd128, 90, 1);
		run_phase(8'd3, 90, 0);
		run_phase(8'd2, 90, 0);
		run_phase(8'd12, 90, 0);
		run_phase(8'd255, 90, 0);
		run_phase(8'd5, 90, 0);
		run_phase(8'd9, 90, 0);
		run_phase(8'd20, 90, 0);
		run_phase(8'd1, 60, 0);
		run_phase(8'd7, 90, 0);

		settle(MAX_C + 20);
		if (sb.errors == 0)
			$display("ALL CHECKS PASSED");
		else
			$display("CHECKS FAILED");
		$finish;
	end

	initial begin
		int stall;
		m_tready = 1'b0;
		stall = 0;
		wait (arst_n === 1'b1);
		forever begin
			@(posedge clk);
			if (m_tvalid && m_tready) begin
				sb.check_child(m_tdata, m_tuser, m_tlast);
				stall = quiet ? 0 : $urandom_range(0, 17);
			end
			if (stall > 0) begin
				if (m_tvalid) stall--;
				m_tready <= 1'b0;
			end else begin
				m_tready <= 1'b1;
			end
		end
	end

	initial begin
		#20000000;
		$display("CHECKS FAILED");
		$finish;
	end

endmodule
